### design/ppp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types, codes and helpers of the perspective point projection block.
// ----------------------------------------------------------------------------
package ppp_pkg;

	// configuration port
	localparam int CFG_IW = 1;
	localparam int CFG_DW = 14;
	localparam logic [CFG_IW-1:0] CFG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_IW-1:0] CFG_SCREEN_HEIGHT = 1'd1;
	localparam logic [CFG_DW-1:0] SCREEN_WIDTH_RST  = 14'd1920;
	localparam logic [CFG_DW-1:0] SCREEN_HEIGHT_RST = 14'd1080;

	// item kinds
	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_PROJECT = 1'b1;

	// column sum width: three shifted 64-bit products plus a 32-bit term
	localparam int SUM_W = 66;
	// quotient magnitude limit is 2^QB raw units
	localparam int QB = 40;
	localparam int QW = QB + 2;
	// divider latency: entry stage, one stage per quotient bit, sign stage
	localparam int DIV_LAT = QB + 2;

	typedef struct packed {
		logic               is_proj;
		logic [3:0]         idx;
		logic signed [31:0] coef;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} item_t;

	// clamp a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### design/ppp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface ppp_item_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic [3:0]         coef_index;
	logic signed [31:0] coef_value;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;

	modport source (output valid, mode, coef_index, coef_value, point_x, point_y, point_z,
		input ready);
	modport sink (input valid, mode, coef_index, coef_value, point_x, point_y, point_z,
		output ready);
endinterface

interface ppp_result_if;
	logic               valid;
	logic               ready;
	logic               visible;
	logic signed [31:0] screen_x;
	logic signed [31:0] screen_y;
	logic signed [31:0] depth;

	modport source (output valid, visible, screen_x, screen_y, depth, input ready);
	modport sink (input valid, visible, screen_x, screen_y, depth, output ready);
endinterface

### design/ppp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_front
// Accepts input items, classifies them as load or project, feeds the queue.
// ----------------------------------------------------------------------------
module ppp_front (
	input  logic           clk,
	input  logic           arst_n,
	ppp_item_if.sink       item,
	output ppp_pkg::item_t push_item,
	output logic           push_valid,
	input  logic           push_ready
);
	import ppp_pkg::*;

	logic  valid_q;
	item_t item_q;

	// take a new item whenever the held one moves on
	assign item.ready = !valid_q || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (item.ready) begin
			valid_q <= item.valid;
		end
	end

	// classify and hold the payload
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_q.is_proj <= (item.mode == MODE_PROJECT);
			item_q.idx     <= item.coef_index;
			item_q.coef    <= item.coef_value;
			item_q.x       <= item.point_x;
			item_q.y       <= item.point_y;
			item_q.z       <= item.point_z;
		end
	end

	assign push_item  = item_q;
	assign push_valid = valid_q;
endmodule

### design/ppp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_queue
// Short FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module ppp_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ppp_pkg::item_t push_item,
	input  logic           push_valid,
	output logic           push_ready,
	output ppp_pkg::item_t pop_item,
	output logic           pop_valid,
	input  logic           pop_ready
);
	import ppp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [0:DEPTH-1];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           push, pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	// store the item
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue overfilled");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1) else $error("count missed push");
	a_count_dn: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1) else $error("count missed pop");
endmodule

### design/ppp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_div
// Pipelined fixed-point divider, one quotient bit per stage, clamped to 2^QB.
// ----------------------------------------------------------------------------
module ppp_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [ppp_pkg::SUM_W-1:0] num,
	input  logic signed [ppp_pkg::SUM_W-1:0] den,
	output logic signed [ppp_pkg::QW-1:0]    quo
);
	import ppp_pkg::*;

	localparam int DW = SUM_W + QB;

	logic [DW-1:0]    rem_q [0:QB];
	logic [DW-1:0]    den_q [0:QB];
	logic [QB-1:0]    qt_q  [0:QB];
	logic             sat_q [0:QB];
	logic             neg_q [0:QB];
	logic signed [QW-1:0] quo_q;

	logic [SUM_W-1:0] num_abs;
	logic [DW-1:0]    num_sh, den_u;
	logic [QW-1:0]    res;

	assign num_abs = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
	assign num_sh  = DW'(num_abs) << FRAC_BITS;
	assign den_u   = DW'(unsigned'(den));

	// entry: scale numerator, flag quotients at or above the limit
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= num_sh;
			den_q[0] <= den_u;
			sat_q[0] <= (num_sh >= (den_u << QB));
			neg_q[0] <= num[SUM_W-1];
			qt_q[0]  <= '0;
		end
	end

	// one restoring step per stage, most significant bit first
	for (genvar s = 1; s <= QB; s++) begin : g_step
		localparam int B = QB - s;
		logic [DW-1:0] trial;
		logic          ge;
		assign trial = den_q[s-1] << B;
		assign ge    = (rem_q[s-1] >= trial);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[s] <= ge ? rem_q[s-1] - trial : rem_q[s-1];
				qt_q[s]  <= qt_q[s-1] | (ge ? (QB'(1) << B) : '0);
				den_q[s] <= den_q[s-1];
				sat_q[s] <= sat_q[s-1];
				neg_q[s] <= neg_q[s-1];
			end
		end
	end

	// clamp and apply sign
	assign res = sat_q[QB] ? (QW'(1) << QB) : QW'(qt_q[QB]);

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q <= neg_q[QB] ? -$signed(res) : $signed(res);
		end
	end

	assign quo = quo_q;
endmodule

### design/ppp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_back
// Holds the matrix, applies loads, transforms, divides and maps project items.
// ----------------------------------------------------------------------------
module ppp_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ppp_pkg::item_t               pop_item,
	input  logic                         pop_valid,
	output logic                         pop_ready,
	input  logic [ppp_pkg::CFG_DW-1:0]   screen_width,
	input  logic [ppp_pkg::CFG_DW-1:0]   screen_height,
	ppp_result_if.source                 result
);
	import ppp_pkg::*;

	localparam logic signed [SUM_W-1:0] VIS_TH = SUM_W'(((1 << FRAC_BITS) + 5) / 10);
	localparam int MW = CFG_DW + 1 + QW;

	logic                     adv;
	logic signed [31:0]       mat_q [0:15];
	logic signed [63:0]       prod_s1 [0:2][0:3];
	logic signed [31:0]       add_s1 [0:3];
	logic                     v_s1;
	logic signed [SUM_W-1:0]  sum_s2 [0:3];
	logic                     v_s2;
	logic                     vld_d [0:DIV_LAT-1];
	logic                     vis_d [0:DIV_LAT-1];
	logic signed [QW-1:0]     nx, ny, nz;
	logic signed [MW-1:0]     mx_s3, my_s3;
	logic signed [QW-1:0]     nx_s3, ny_s3, nz_s3;
	logic                     v_s3, vis_s3;
	logic                     out_v_q, out_vis_q;
	logic signed [31:0]       out_x_q, out_y_q, out_z_q;
	logic signed [63:0]       sx, sy, half_w, half_h;

	// the whole back advances as one when the output can move
	assign adv       = !out_v_q || result.ready;
	assign pop_ready = adv;

	// apply loads; valid bits of the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				mat_q[i] <= '0;
			end
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				vld_d[i] <= 1'b0;
			end
		end else if (adv) begin
			if (pop_valid && !pop_item.is_proj) begin
				mat_q[pop_item.idx] <= pop_item.coef;
			end
			v_s1     <= pop_valid && pop_item.is_proj;
			v_s2     <= v_s1;
			vld_d[0] <= v_s2;
			for (int i = 1; i < DIV_LAT; i++) begin
				vld_d[i] <= vld_d[i-1];
			end
			v_s3    <= vld_d[DIV_LAT-1];
			out_v_q <= v_s3;
		end
	end

	// multiply point by matrix rows
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++) begin
				prod_s1[0][c] <= pop_item.x * mat_q[c];
				prod_s1[1][c] <= pop_item.y * mat_q[4 + c];
				prod_s1[2][c] <= pop_item.z * mat_q[8 + c];
				add_s1[c]     <= mat_q[12 + c];
			end
		end
	end

	// sum each column
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++) begin
				sum_s2[c] <= SUM_W'(prod_s1[0][c] >>> FRAC_BITS)
					+ SUM_W'(prod_s1[1][c] >>> FRAC_BITS)
					+ SUM_W'(prod_s1[2][c] >>> FRAC_BITS)
					+ SUM_W'(add_s1[c]);
			end
		end
	end

	// carry visibility alongside the dividers
	always_ff @(posedge clk) begin
		if (adv) begin
			vis_d[0] <= (sum_s2[3] >= VIS_TH);
			for (int i = 1; i < DIV_LAT; i++) begin
				vis_d[i] <= vis_d[i-1];
			end
		end
	end

	ppp_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk(clk), .en(adv), .num(sum_s2[0]), .den(sum_s2[3]), .quo(nx));
	ppp_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk(clk), .en(adv), .num(sum_s2[1]), .den(sum_s2[3]), .quo(ny));
	ppp_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
		.clk(clk), .en(adv), .num(sum_s2[2]), .den(sum_s2[3]), .quo(nz));

	// scale by screen size
	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s3  <= $signed({1'b0, screen_width}) * nx;
			my_s3  <= $signed({1'b0, screen_height}) * ny;
			nx_s3  <= nx;
			ny_s3  <= ny;
			nz_s3  <= nz;
			vis_s3 <= vis_d[DIV_LAT-1];
		end
	end

	// offset to screen center, flip y, saturate
	assign half_w = $signed(64'(screen_width) << (FRAC_BITS - 1));
	assign half_h = $signed(64'(screen_height) << (FRAC_BITS - 1));
	assign sx = 64'(mx_s3 >>> 1) + 64'(nx_s3) + half_w;
	assign sy = -64'(my_s3 >>> 1) + 64'(ny_s3) + half_h;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_vis_q <= vis_s3;
			out_x_q   <= vis_s3 ? sat32(sx) : '0;
			out_y_q   <= vis_s3 ? sat32(sy) : '0;
			out_z_q   <= vis_s3 ? sat32(64'(nz_s3)) : '0;
		end
	end

	assign result.valid    = out_v_q;
	assign result.visible  = out_vis_q;
	assign result.screen_x = out_x_q;
	assign result.screen_y = out_y_q;
	assign result.depth    = out_z_q;

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_vis_q |-> out_x_q == 0 && out_y_q == 0 && out_z_q == 0)
		else $error("hidden point with nonzero coordinates");
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		adv && pop_valid && !pop_item.is_proj |=> !v_s1)
		else $error("load item entered the transform");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> out_v_q) else $error("stalled result dropped");
endmodule

### design/perspective_point_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_point_projection
// Projects points through a stored 4x4 matrix to screen pixels (fixed point).
// ----------------------------------------------------------------------------
// channel   dir   handshake        payload
// item      in    valid/ready      mode, coef_index, coef_value, point_x/y/z
// result    out   valid/ready      visible, screen_x, screen_y, depth
// cfg       in    cfg_we           cfg_index, cfg_data
//
// One item per cycle sustained; load items take a slot but give no result.
// On its way to a result an item is registered in this order: the front register
// loads at the accepting edge, then queue, two transform stages, DIV_LAT (42)
// divider stages, two mapping stages. The matrix clears at reset; no clearing
// pass. A stalled result freezes the back; the front and queue keep taking
// items until the queue fills.
// ----------------------------------------------------------------------------
module perspective_point_projection #(
	parameter int FRAC_BITS   = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ppp_item_if.sink                    item,
	ppp_result_if.source                result,
	input  logic                        cfg_we,
	input  logic [ppp_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [ppp_pkg::CFG_DW-1:0]  cfg_data
);
	import ppp_pkg::*;

	logic [CFG_DW-1:0] screen_width_q, screen_height_q;
	item_t             push_item, pop_item;
	logic              push_valid, push_ready, pop_valid, pop_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCREEN_WIDTH: begin
					screen_width_q <= cfg_data;
				end
				CFG_SCREEN_HEIGHT: begin
					screen_height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	ppp_front u_front (
		.clk(clk), .arst_n(arst_n), .item(item),
		.push_item(push_item), .push_valid(push_valid), .push_ready(push_ready));

	ppp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_item(push_item), .push_valid(push_valid), .push_ready(push_ready),
		.pop_item(pop_item), .pop_valid(pop_valid), .pop_ready(pop_ready));

	ppp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.pop_item(pop_item), .pop_valid(pop_valid), .pop_ready(pop_ready),
		.screen_width(screen_width_q), .screen_height(screen_height_q),
		.result(result));
endmodule
